>>> src/cwac_pkg.sv
package cwac_pkg;

	localparam int NUM_SUBJECTS_DEF = 16;
	localparam int NUM_OBJECTS_DEF  = 16;
	localparam int NUM_FIRMS_DEF    = 16;

	localparam int ID_W       = 4;
	localparam int MAP_W      = 64;
	localparam int SET_W      = 16;
	localparam int IN_USER_W  = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 88;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_QUERY = 2'd3
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OBJECT_FIRM_MAP = 1'b0,
		CFG_FIRM_CLASS_MAP  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EVAL = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic eval;
	} dp_cmd_t;

endpackage

>>> src/cwac_datapath.sv
module cwac_datapath #(
	parameter int NUM_SUBJECTS = cwac_pkg::NUM_SUBJECTS_DEF,
	parameter int NUM_OBJECTS  = cwac_pkg::NUM_OBJECTS_DEF,
	parameter int NUM_FIRMS    = cwac_pkg::NUM_FIRMS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  cwac_pkg::dp_cmd_t                         cmd,
	input  logic [cwac_pkg::IN_USER_W-1:0]            in_user,
	input  logic [cwac_pkg::IN_DATA_W-1:0]            in_data,
	input  logic                                      cfg_wr,
	input  logic [cwac_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [cwac_pkg::MAP_W-1:0]                cfg_data,
	output logic [cwac_pkg::OUT_DATA_W-1:0]           out_data
);
	import cwac_pkg::*;

	localparam int SUBJ_DEPTH = (NUM_SUBJECTS < 16) ? NUM_SUBJECTS : 16;
	localparam int SAW = $clog2(SUBJ_DEPTH);
	localparam int OAW = $clog2(NUM_OBJECTS);
	localparam int PAD_W = OUT_DATA_W - 1 - 5 * SET_W;

	logic [MAP_W-1:0] fmap_q;
	logic [MAP_W-1:0] cmap_q;

	logic [SET_W-1:0] subj_rd_q [SUBJ_DEPTH];
	logic [SET_W-1:0] subj_wr_q [SUBJ_DEPTH];
	logic [SET_W-1:0] obj_rd_q  [NUM_OBJECTS];
	logic [SET_W-1:0] obj_wr_q  [NUM_OBJECTS];

	req_type_t         req_q;
	logic [ID_W-1:0]   sub_q;
	logic [ID_W-1:0]   obj_q;
	logic [ID_W-1:0]   fq_q;

	logic [SAW-1:0]    s_addr;
	logic [OAW-1:0]    o_addr;
	logic              s_ok;
	logic              o_ok;
	logic              is_access;
	logic              is_write;
	logic              allow;
	logic              rec;
	logic [ID_W-1:0]   tgt_firm;
	logic [ID_W-1:0]   tgt_class;
	logic [SET_W-1:0]  rs;
	logic [SET_W-1:0]  obj_bit;
	logic [SET_W-1:0]  sub_bit;
	logic [SET_W-1:0]  nxt_sr;
	logic [SET_W-1:0]  nxt_sw;
	logic [SET_W-1:0]  nxt_or;
	logic [SET_W-1:0]  nxt_ow;
	logic [SET_W-1:0]  bcase;
	logic              granted;

	logic [OUT_DATA_W-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmap_q <= '0;
			cmap_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_OBJECT_FIRM_MAP: fmap_q <= cfg_data;
				CFG_FIRM_CLASS_MAP:  cmap_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type_t'(in_user);
			sub_q <= in_data[ID_W-1:0];
			obj_q <= in_data[2*ID_W-1:ID_W];
			fq_q  <= in_data[3*ID_W-1:2*ID_W];
		end
	end

	assign s_addr    = SAW'(sub_q);
	assign o_addr    = OAW'(obj_q);
	assign s_ok      = {28'd0, sub_q} < 32'(NUM_SUBJECTS);
	assign o_ok      = {28'd0, obj_q} < 32'(NUM_OBJECTS);
	assign is_access = (req_q == REQ_READ) || (req_q == REQ_WRITE);
	assign is_write  = (req_q == REQ_WRITE);
	assign tgt_firm  = fmap_q[{obj_q, 2'b00} +: ID_W];
	assign tgt_class = cmap_q[{tgt_firm, 2'b00} +: ID_W];
	assign rs        = s_ok ? subj_rd_q[s_addr] : '0;
	assign obj_bit   = SET_W'(1) << obj_q;
	assign sub_bit   = SET_W'(1) << sub_q;

	always_comb begin
		logic [ID_W-1:0] fi;
		allow = 1'b1;
		bcase = '0;
		for (int i = 0; i < NUM_OBJECTS; i++) begin
			fi = fmap_q[4*i +: ID_W];
			if (rs[i]) begin
				if (is_write) begin
					if (fi != tgt_firm) allow = 1'b0;
				end else if (fi != tgt_firm && cmap_q[{fi, 2'b00} +: ID_W] == tgt_class) begin
					allow = 1'b0;
				end
			end
			if (({28'd0, fq_q} < 32'(NUM_FIRMS)) && fi == fq_q) bcase[i] = 1'b1;
		end
	end

	assign rec     = is_access && s_ok && o_ok && allow;
	assign granted = is_access ? rec : 1'b1;

	always_comb begin
		if (req_q == REQ_CLEAR) begin
			nxt_sr = '0;
			nxt_sw = '0;
			nxt_or = '0;
			nxt_ow = '0;
		end else begin
			nxt_sr = (s_ok ? subj_rd_q[s_addr] : '0) | (rec ? obj_bit : '0);
			nxt_sw = (s_ok ? subj_wr_q[s_addr] : '0) | ((rec && is_write) ? obj_bit : '0);
			nxt_or = (o_ok ? obj_rd_q[o_addr] : '0) | (rec ? sub_bit : '0);
			nxt_ow = (o_ok ? obj_wr_q[o_addr] : '0) | ((rec && is_write) ? sub_bit : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SUBJ_DEPTH; i++) begin
				subj_rd_q[i] <= '0;
				subj_wr_q[i] <= '0;
			end
			for (int j = 0; j < NUM_OBJECTS; j++) begin
				obj_rd_q[j] <= '0;
				obj_wr_q[j] <= '0;
			end
		end else if (cmd.eval) begin
			if (req_q == REQ_CLEAR) begin
				for (int i = 0; i < SUBJ_DEPTH; i++) begin
					subj_rd_q[i] <= '0;
					subj_wr_q[i] <= '0;
				end
				for (int j = 0; j < NUM_OBJECTS; j++) begin
					obj_rd_q[j] <= '0;
					obj_wr_q[j] <= '0;
				end
			end else if (rec) begin
				subj_rd_q[s_addr] <= nxt_sr;
				subj_wr_q[s_addr] <= nxt_sw;
				obj_rd_q[o_addr]  <= nxt_or;
				obj_wr_q[o_addr]  <= nxt_ow;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			out_q <= {{PAD_W{1'b0}}, bcase, nxt_ow, nxt_or, nxt_sw, nxt_sr, granted};
		end
	end

	assign out_data = out_q;

endmodule

>>> src/cwac_ctrl.sv
module cwac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cwac_pkg::dp_cmd_t cmd
);
	import cwac_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_EVAL;
			ST_EVAL: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EVAL: cmd.eval = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.eval) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_eval_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> (!out_valid_q || out_ready))
		else $error("Result overwritten before it was taken.");

	a_load_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_EVAL))
		else $error("Accepted request did not move to evaluation.");

	a_eval_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |=> out_valid_q)
		else $error("Evaluated request produced no result.");

	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EVAL))
		else $error("Result appeared without an evaluation.");

endmodule

>>> src/chinese_wall_access_checker_core.sv
// Channel   Direction  Handshake                       Contents
// s_axis    in         s_axis_tvalid / s_axis_tready   one access request
// m_axis    out        m_axis_tvalid / m_axis_tready   grant bit, history bitmaps and briefcase
// cfg       in         cfg_valid / cfg_ready           register index and 64-bit data
//
// A request is captured in the idle state, then decided in the evaluation state, which
// also updates the history sets; a new request is accepted only once that is done.
// The output register lets a new request be captured while a result waits.
// A stalled result holds the evaluation stage until the result is taken.
// Reset clears the history sets and both maps; the configuration port is always ready.
module chinese_wall_access_checker_core #(
	parameter int NUM_SUBJECTS = cwac_pkg::NUM_SUBJECTS_DEF,
	parameter int NUM_OBJECTS  = cwac_pkg::NUM_OBJECTS_DEF,
	parameter int NUM_FIRMS    = cwac_pkg::NUM_FIRMS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// req_type
	input  logic [cwac_pkg::IN_USER_W-1:0]        s_axis_tuser,
	// subject_index, object_index, firm_query, zero pad
	input  logic [cwac_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// granted, subject_reads, subject_writes, object_readers, object_writers,
	// briefcase, zero pad
	output logic [cwac_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cwac_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cwac_pkg::MAP_W-1:0]            cfg_data
);
	import cwac_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	cwac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	cwac_datapath #(
		.NUM_SUBJECTS (NUM_SUBJECTS),
		.NUM_OBJECTS  (NUM_OBJECTS),
		.NUM_FIRMS    (NUM_FIRMS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata)
	);

endmodule

>>> test/chinese_wall_access_checker_core_tb.sv
module chinese_wall_access_checker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cwac_pkg::*;

	typedef struct packed {
		logic        granted;
		logic [15:0] subj_reads;
		logic [15:0] subj_writes;
		logic [15:0] obj_readers;
		logic [15:0] obj_writers;
		logic [15:0] briefcase;
	} access_decision_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_USER_W-1:0]   s_axis_tuser = '0;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [MAP_W-1:0]       cfg_data = '0;

	logic [63:0] object_firms = '0;
	logic [63:0] firm_classes = '0;
	logic [15:0] reads_by_subject [16];
	logic [15:0] writes_by_subject [16];
	logic [15:0] readers_of_object [16];
	logic [15:0] writers_of_object [16];

	access_decision_t pending_decisions [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int error_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int grants_seen = 0;
	int refusals_seen = 0;
	int clears_sent = 0;

	chinese_wall_access_checker_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [3:0] firm_of_object(logic [3:0] obj);
		return object_firms[int'(obj) * 4 +: 4];
	endfunction

	function automatic logic [3:0] class_of_firm(logic [3:0] firm);
		return firm_classes[int'(firm) * 4 +: 4];
	endfunction

	function automatic void clear_histories();
		for (int i = 0; i < 16; i++) begin
			reads_by_subject[i] = '0;
			writes_by_subject[i] = '0;
			readers_of_object[i] = '0;
			writers_of_object[i] = '0;
		end
	endfunction

	function automatic access_decision_t evaluate_access(req_type_t req, logic [3:0] subj,
			logic [3:0] obj, logic [3:0] firm);
		access_decision_t d;
		logic [3:0] target_firm;
		logic [3:0] target_class;
		logic [3:0] held_firm;
		logic ok;
		d = '0;
		d.granted = 1'b1;
		if (req == REQ_READ || req == REQ_WRITE) begin
			target_firm = firm_of_object(obj);
			target_class = class_of_firm(target_firm);
			ok = 1'b1;
			for (int i = 0; i < 16; i++) begin
				if (reads_by_subject[subj][i]) begin
					held_firm = firm_of_object(i[3:0]);
					if (req == REQ_READ) begin
						if (held_firm != target_firm && class_of_firm(held_firm) == target_class)
							ok = 1'b0;
					end else if (held_firm != target_firm) begin
						ok = 1'b0;
					end
				end
			end
			d.granted = ok;
			if (ok) begin
				reads_by_subject[subj][obj] = 1'b1;
				readers_of_object[obj][subj] = 1'b1;
				if (req == REQ_WRITE) begin
					writes_by_subject[subj][obj] = 1'b1;
					writers_of_object[obj][subj] = 1'b1;
				end
			end
		end else if (req == REQ_CLEAR) begin
			clear_histories();
		end
		for (int i = 0; i < 16; i++)
			if (firm_of_object(i[3:0]) == firm)
				d.briefcase[i] = 1'b1;
		d.subj_reads = reads_by_subject[subj];
		d.subj_writes = writes_by_subject[subj];
		d.obj_readers = readers_of_object[obj];
		d.obj_writers = writers_of_object[obj];
		return d;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		if (error_count < 100)
			$display("Mismatch in %s at %0t ns: got %h, expected %h", what, $time, got, want);
		error_count++;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		access_decision_t got;
		access_decision_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.granted = m_axis_tdata[0];
			got.subj_reads = m_axis_tdata[16:1];
			got.subj_writes = m_axis_tdata[32:17];
			got.obj_readers = m_axis_tdata[48:33];
			got.obj_writers = m_axis_tdata[64:49];
			got.briefcase = m_axis_tdata[80:65];
			if (pending_decisions.size() == 0) begin
				report_mismatch("unrequested result", m_axis_tdata[15:0], '0);
			end else begin
				want = pending_decisions.pop_front();
				results_checked++;
				if (want.granted)
					grants_seen++;
				else
					refusals_seen++;
				if (got.granted != want.granted)
					report_mismatch("granted", 16'(got.granted), 16'(want.granted));
				if (got.subj_reads != want.subj_reads)
					report_mismatch("subject_reads", got.subj_reads, want.subj_reads);
				if (got.subj_writes != want.subj_writes)
					report_mismatch("subject_writes", got.subj_writes, want.subj_writes);
				if (got.obj_readers != want.obj_readers)
					report_mismatch("object_readers", got.obj_readers, want.obj_readers);
				if (got.obj_writers != want.obj_writers)
					report_mismatch("object_writers", got.obj_writers, want.obj_writers);
				if (got.briefcase != want.briefcase)
					report_mismatch("briefcase", got.briefcase, want.briefcase);
			end
		end
	end

	task automatic send_request(req_type_t req, logic [3:0] subj, logic [3:0] obj,
			logic [3:0] firm);
		access_decision_t expected;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {4'b0000, firm, obj, subj};
		do @(posedge clk); while (!s_axis_tready);
		expected = evaluate_access(req, subj, obj, firm);
		pending_decisions.insert(pending_decisions.size(), expected);
		requests_sent++;
		if (req == REQ_CLEAR)
			clears_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(cfg_reg_t idx, logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_OBJECT_FIRM_MAP)
			object_firms = value;
		else
			firm_classes = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] narrow_map(int top);
		logic [63:0] m;
		for (int i = 0; i < 16; i++)
			m[i * 4 +: 4] = 4'($urandom_range(top));
		return m;
	endfunction

	task automatic random_request(int pool_size);
		req_type_t req;
		logic [3:0] subj;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			req = REQ_READ;
		else if (pick < 75)
			req = REQ_WRITE;
		else if (pick < 78)
			req = REQ_CLEAR;
		else
			req = REQ_QUERY;
		if ($urandom_range(99) < 70)
			subj = 4'($urandom_range(pool_size - 1));
		else
			subj = 4'($urandom_range(15));
		send_request(req, subj, 4'($urandom_range(15)), 4'($urandom_range(15)));
	endtask

	task automatic randomize_maps();
		case ($urandom_range(3))
			0: begin
				write_config(CFG_OBJECT_FIRM_MAP, narrow_map(3));
				write_config(CFG_FIRM_CLASS_MAP, narrow_map(1));
			end
			1: begin
				write_config(CFG_OBJECT_FIRM_MAP, {$urandom, $urandom});
				write_config(CFG_FIRM_CLASS_MAP, {$urandom, $urandom});
			end
			2: begin
				write_config(CFG_OBJECT_FIRM_MAP, narrow_map(7));
				write_config(CFG_FIRM_CLASS_MAP, narrow_map(3));
			end
			default: begin
				write_config(CFG_OBJECT_FIRM_MAP, $urandom_range(1) ? '1 : '0);
				write_config(CFG_FIRM_CLASS_MAP, $urandom_range(1) ? '1 : narrow_map(1));
			end
		endcase
	endtask

	task automatic test_reset_defaults();
		send_request(REQ_QUERY, 4'd0, 4'd0, 4'd0);
		send_request(REQ_READ, 4'd0, 4'd15, 4'd15);
		send_request(REQ_WRITE, 4'd15, 4'd15, 4'd0);
		send_request(REQ_READ, 4'd15, 4'd0, 4'd1);
		wait_drain();
	endtask

	task automatic test_policy_directed();
		write_config(CFG_OBJECT_FIRM_MAP, 64'hFFFF_3333_2222_1111);
		write_config(CFG_FIRM_CLASS_MAP, 64'hF000_0000_0000_6550);
		send_request(REQ_CLEAR, 4'd0, 4'd0, 4'd0);
		send_request(REQ_READ, 4'd1, 4'd0, 4'd1);
		send_request(REQ_READ, 4'd1, 4'd1, 4'd1);
		send_request(REQ_READ, 4'd1, 4'd4, 4'd2);
		send_request(REQ_READ, 4'd1, 4'd8, 4'd3);
		send_request(REQ_WRITE, 4'd1, 4'd2, 4'd1);
		send_request(REQ_WRITE, 4'd2, 4'd12, 4'd15);
		send_request(REQ_WRITE, 4'd2, 4'd13, 4'd15);
		send_request(REQ_READ, 4'd2, 4'd0, 4'd1);
		send_request(REQ_WRITE, 4'd2, 4'd14, 4'd4);
		send_request(REQ_QUERY, 4'd1, 4'd0, 4'd2);
		send_request(REQ_CLEAR, 4'd2, 4'd12, 4'd3);
		send_request(REQ_READ, 4'd1, 4'd4, 4'd2);
		send_request(REQ_QUERY, 4'd15, 4'd15, 4'd15);
		wait_drain();
	endtask

	task automatic test_map_extremes();
		write_config(CFG_OBJECT_FIRM_MAP, '1);
		write_config(CFG_FIRM_CLASS_MAP, '1);
		send_request(REQ_QUERY, 4'd15, 4'd15, 4'd15);
		send_request(REQ_READ, 4'd15, 4'd15, 4'd0);
		send_request(REQ_WRITE, 4'd15, 4'd0, 4'd15);
		wait_drain();
		write_config(CFG_OBJECT_FIRM_MAP, '0);
		write_config(CFG_FIRM_CLASS_MAP, '0);
		send_request(REQ_WRITE, 4'd15, 4'd7, 4'd0);
		send_request(REQ_READ, 4'd3, 4'd15, 4'd15);
		wait_drain();
	endtask

	task automatic test_output_backpressure();
		write_config(CFG_OBJECT_FIRM_MAP, narrow_map(3));
		write_config(CFG_FIRM_CLASS_MAP, narrow_map(1));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 80;
		repeat (24) random_request(4);
		wait_drain();
		repeat (10) begin
			random_request(4);
			wait_drain();
		end
	endtask

	task automatic run_random_phase(int idle_pct, int stall_pct, int chunk_items);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (3) begin
			randomize_maps();
			repeat (chunk_items) random_request($urandom_range(1) ? 3 : 16);
			wait_drain();
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 0, 50);
		run_random_phase(70, 0, 50);
		run_random_phase(0, 70, 50);
		run_random_phase(23, 23, 50);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		clear_histories();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_policy_directed();
		test_map_extremes();
		test_output_backpressure();
		test_random_traffic();
		wait_drain();
		repeat (10) @(posedge clk);
		$display("Checked %0d of %0d requests: %0d granted, %0d refused, %0d history clears.",
			results_checked, requests_sent, grants_seen, refusals_seen, clears_sent);
		$display("Covered directed wall cases, map extremes, a long output stall and four idle mixes.");
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
